/* hdl/lights_darks_pixel_adjust_unit_defines.svh */
// Assertion macros for the lights/darks pixel adjust unit.
// Taken in by the top level; needs clk and rst_n in the including scope.
`ifndef LIGHTS_DARKS_PIXEL_ADJUST_UNIT_DEFINES_SVH
`define LIGHTS_DARKS_PIXEL_ADJUST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LDPA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LDPA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ldpa_pkg.sv */
// Shared types and constants of the lights/darks pixel adjust unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package ldpa_pkg;

  localparam int CH_W    = 8;
  localparam int GAIN_W  = 9;
  localparam int SUM_W   = 20;
  localparam int B8_W    = 16;
  localparam int DIFF_W  = 16;
  localparam int RECIP_W = 6;
  localparam int PROD_W  = GAIN_W + DIFF_W + 1;
  localparam int P_W     = PROD_W + RECIP_W + 1;
  localparam int D8_W    = 18;
  localparam int C8_W    = 19;
  localparam int LVL_W   = C8_W - 8;
  localparam int FRAC_SH = 12;

  localparam int LIGHTS_LEVEL = 150;

  localparam logic [11:0] W_RED   = 12'd1229;
  localparam logic [11:0] W_GREEN = 12'd2458;
  localparam logic [11:0] W_BLUE  = 12'd410;

  localparam logic [B8_W-1:0]    LIGHTS_B8   = 16'd38400;
  localparam logic [B8_W-1:0]    DARKS_B8    = 16'd33280;
  localparam logic [RECIP_W-1:0] RECIP_DARKS = 6'd32;
  localparam logic [P_W-1:0]     FRAC_MASK   = P_W'(4095);

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  typedef enum logic [0:0] {
    CFG_LIGHTS = 1'b0,
    CFG_DARKS  = 1'b1
  } cfg_idx_t;

endpackage

`default_nettype wire

/* hdl/ldpa_luma.sv */
// Stage 1: weighted brightness of the incoming pixel, 8 fractional bits.
// Depends on ldpa_pkg.
`default_nettype none

module ldpa_luma import ldpa_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pix_t            pix_i,
  output logic            out_valid,
  input  logic            out_ready,
  output pix_t            pix_o,
  output logic [B8_W-1:0] b8_o
);

  logic            v_r;
  pix_t            pix_r;
  logic [B8_W-1:0] b8_r;
  logic [SUM_W-1:0] sum_nxt;

  assign in_ready = !v_r || out_ready;

  always_comb begin
    sum_nxt = SUM_W'(pix_i.red) * SUM_W'(W_RED)
            + SUM_W'(pix_i.green) * SUM_W'(W_GREEN)
            + SUM_W'(pix_i.blue) * SUM_W'(W_BLUE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix_r <= pix_i;
      b8_r  <= sum_nxt[SUM_W-1:4];
    end
  end

  assign out_valid = v_r;
  assign pix_o     = pix_r;
  assign b8_o      = b8_r;

endmodule

`default_nettype wire

/* hdl/ldpa_gain.sv */
// Stages 2 and 3: mode select, gain times offset, then times the reciprocal.
// Depends on ldpa_pkg.
`default_nettype none

module ldpa_gain import ldpa_pkg::*; #(
  parameter int CHANNEL_MAX = 255
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [GAIN_W-1:0] lights_gain,
  input  logic signed [GAIN_W-1:0] darks_gain,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pix_t                     pix_i,
  input  logic [B8_W-1:0]          b8_i,
  output logic                     out_valid,
  input  logic                     out_ready,
  output pix_t                     pix_o,
  output logic signed [P_W-1:0]    p_o
);

  localparam int LIGHTS_SPAN = CHANNEL_MAX - LIGHTS_LEVEL;
  localparam int RECIP_LIGHTS_I = (4096 + LIGHTS_SPAN / 2) / LIGHTS_SPAN;
  localparam logic [RECIP_W-1:0] RECIP_LIGHTS = RECIP_LIGHTS_I[RECIP_W-1:0];

  // Stage 2 registers.
  logic                      v2_r;
  pix_t                      pix2_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [RECIP_W-1:0]        recip_r;
  // Stage 3 registers.
  logic                      v3_r;
  pix_t                      pix3_r;
  logic signed [P_W-1:0]     p_r;

  logic                      ready2;
  logic                      lights_sel;
  logic                      darks_sel;
  logic signed [GAIN_W-1:0]  gain_sel;
  logic [DIFF_W-1:0]         diff_sel;
  logic [RECIP_W-1:0]        recip_nxt;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [P_W-1:0]     p_nxt;

  assign ready2   = !v3_r || out_ready;
  assign in_ready = !v2_r || ready2;

  // Highlights win when both conditions could apply.
  always_comb begin
    lights_sel = (lights_gain != '0) && (b8_i > LIGHTS_B8);
    darks_sel  = (darks_gain != '0) && (b8_i < DARKS_B8);
    priority if (lights_sel) begin
      gain_sel  = lights_gain;
      diff_sel  = b8_i - LIGHTS_B8;
      recip_nxt = RECIP_LIGHTS;
    end else if (darks_sel) begin
      gain_sel  = darks_gain;
      diff_sel  = DARKS_B8 - b8_i;
      recip_nxt = RECIP_DARKS;
    end else begin
      gain_sel  = '0;
      diff_sel  = '0;
      recip_nxt = '0;
    end
    prod_nxt = gain_sel * $signed({1'b0, diff_sel});
    p_nxt    = prod_r * $signed({1'b0, recip_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (in_ready) begin
        v2_r <= in_valid;
      end
      if (ready2) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix2_r  <= pix_i;
      prod_r  <= prod_nxt;
      recip_r <= recip_nxt;
    end
    if (v2_r && ready2) begin
      pix3_r <= pix2_r;
      p_r    <= p_nxt;
    end
  end

  assign out_valid = v3_r;
  assign pix_o     = pix3_r;
  assign p_o       = p_r;

endmodule

`default_nettype wire

/* hdl/ldpa_apply.sv */
// Stage 4: scale the delta, add it to each channel, clamp; output register.
// Depends on ldpa_pkg.
`default_nettype none

module ldpa_apply import ldpa_pkg::*; #(
  parameter int CHANNEL_MAX = 255
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pix_t                  pix_i,
  input  logic signed [P_W-1:0] p_i,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pix_t                  pix_o
);

  localparam logic [LVL_W-1:0] CH_MAX_L = CHANNEL_MAX[LVL_W-1:0];

  logic                   v_r;
  pix_t                   pix_r;
  logic signed [P_W-1:0]  p_adj;
  logic signed [D8_W-1:0] d8;
  pix_t                   pix_nxt;

  function automatic logic [CH_W-1:0] finish_ch(input logic [CH_W-1:0] ch,
                                                input logic signed [D8_W-1:0] d);
    logic signed [C8_W-1:0] c8;
    logic [LVL_W-1:0]       lvl;
    c8  = $signed({{(C8_W-CH_W-8){1'b0}}, ch, 8'h00})
        + $signed({{(C8_W-D8_W){d[D8_W-1]}}, d});
    lvl = c8[C8_W-1:8];
    if (c8[C8_W-1]) begin
      finish_ch = '0;
    end else if (lvl > CH_MAX_L) begin
      finish_ch = CH_MAX_L[CH_W-1:0];
    end else begin
      finish_ch = lvl[CH_W-1:0];
    end
  endfunction

  assign in_ready = !v_r || out_ready;

  // Division by 4096 truncating toward zero: bias negative values first.
  always_comb begin
    p_adj = p_i + (p_i[P_W-1] ? FRAC_MASK : '0);
    d8    = p_adj[FRAC_SH+D8_W-1:FRAC_SH];
    pix_nxt.red   = finish_ch(pix_i.red, d8);
    pix_nxt.green = finish_ch(pix_i.green, d8);
    pix_nxt.blue  = finish_ch(pix_i.blue, d8);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_valid = v_r;
  assign pix_o     = pix_r;

endmodule

`default_nettype wire

/* hdl/lights_darks_pixel_adjust_unit.sv */
// Top level of the lights/darks (shadows/highlights) pixel adjust unit.
// Depends on ldpa_pkg, ldpa_luma, ldpa_gain, ldpa_apply and the defines header.
//
// Usage:
//   One RGB pixel item enters on the in_ channel (valid/ready) and one adjusted
//   pixel item leaves on the out_ channel (valid/ready). The cfg_ channel writes
//   the lights gain (index CFG_LIGHTS) and the darks gain (index CFG_DARKS); it
//   is always ready and should only be used while the pipeline is empty.
//   The datapath is a four-stage pipeline: brightness, gain times offset,
//   times reciprocal, then channel add and clamp into the output register.
//   An accepted item passes through the stage 1, 2 and 3 registers and then the
//   output register, where out_valid rises. Throughput is one item per cycle,
//   bounded only by the receiver taking items.
//   When out_ready is low, items stay in their stages and in_ready drops once
//   every stage holds an item; nothing is lost or repeated. in_ready is high
//   whenever any stage in front of the stall has room.
//   Synchronous reset (rst_n low) empties the pipeline and clears both gains,
//   so the unit passes pixels through unchanged until a gain is written.
`default_nettype none

`include "lights_darks_pixel_adjust_unit_defines.svh"

module lights_darks_pixel_adjust_unit import ldpa_pkg::*; #(
  parameter int CHANNEL_MAX = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CH_W-1:0]   in_red_in,
  input  logic [CH_W-1:0]   in_green_in,
  input  logic [CH_W-1:0]   in_blue_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CH_W-1:0]   out_red_out,
  output logic [CH_W-1:0]   out_green_out,
  output logic [CH_W-1:0]   out_blue_out,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  cfg_idx_t          cfg_index,
  input  logic [GAIN_W-1:0] cfg_data
);

  // Gain registers, written through the configuration channel.
  logic signed [GAIN_W-1:0] lights_gain_r;
  logic signed [GAIN_W-1:0] darks_gain_r;

  pix_t                  pix_in;
  pix_t                  pix1;
  pix_t                  pix3;
  pix_t                  pix_out;
  logic [B8_W-1:0]       b8_1;
  logic signed [P_W-1:0] p3;
  logic                  v1;
  logic                  rdy1;
  logic                  v3;
  logic                  rdy3;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lights_gain_r <= '0;
      darks_gain_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LIGHTS: lights_gain_r <= cfg_data;
        CFG_DARKS:  darks_gain_r  <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign pix_in.red   = in_red_in;
  assign pix_in.green = in_green_in;
  assign pix_in.blue  = in_blue_in;

  // Stage 1: brightness.
  ldpa_luma u_luma (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pix_i     (pix_in),
    .out_valid (v1),
    .out_ready (rdy1),
    .pix_o     (pix1),
    .b8_o      (b8_1)
  );

  // Stages 2 and 3: select the adjustment and form the scaled delta.
  ldpa_gain #(
    .CHANNEL_MAX (CHANNEL_MAX)
  ) u_gain (
    .clk         (clk),
    .rst_n       (rst_n),
    .lights_gain (lights_gain_r),
    .darks_gain  (darks_gain_r),
    .in_valid    (v1),
    .in_ready    (rdy1),
    .pix_i       (pix1),
    .b8_i        (b8_1),
    .out_valid   (v3),
    .out_ready   (rdy3),
    .pix_o       (pix3),
    .p_o         (p3)
  );

  // Stage 4: apply the delta and hold the result for the receiver.
  ldpa_apply #(
    .CHANNEL_MAX (CHANNEL_MAX)
  ) u_apply (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3),
    .in_ready  (rdy3),
    .pix_i     (pix3),
    .p_i       (p3),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pix_o     (pix_out)
  );

  assign out_red_out   = pix_out.red;
  assign out_green_out = pix_out.green;
  assign out_blue_out  = pix_out.blue;

  // An accepted item always lands in the first stage.
  `LDPA_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, v1, "accepted item lost in stage 1")
  // With the output register empty, every stage can move, so input is taken.
  `LDPA_ASSERT_IMPL(a_empty_out_ready, !out_valid, in_ready, "input stalled with empty output")
  // A full, stalled pipeline must refuse new input.
  `LDPA_ASSERT_IMPL(a_full_blocks, v1 && v3 && out_valid && !out_ready && !rdy1, !in_ready,
                    "input taken while pipeline full")

endmodule

`default_nettype wire
